>>> design/ppb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppb_pkg: shared types and constants for the piece progress bitmap
// Request and response payloads, function codes, status codes and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package ppb_pkg;

	// Default store depth (pieces)
	localparam int PPB_MAX_PIECES = 16384;

	// Field widths fixed by the interface
	localparam int CNT_W   = 15;
	localparam int IDX_W   = 14;
	localparam int SIZE_W  = 25;
	localparam int BYTES_W = 40;

	// Configuration port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Register indexes (word address = paddr[3:2])
	localparam logic [1:0] REG_PIECE_COUNT = 2'd0;
	localparam logic [1:0] REG_PIECE_SIZE  = 2'd1;
	localparam logic [1:0] REG_LAST_SIZE   = 2'd2;

	// Function codes
	localparam logic [2:0] FN_ADD      = 3'd0;
	localparam logic [2:0] FN_REMOVE   = 3'd1;
	localparam logic [2:0] FN_SELECT   = 3'd2;
	localparam logic [2:0] FN_DESELECT = 3'd3;
	localparam logic [2:0] FN_QUERY    = 3'd4;
	localparam logic [2:0] FN_FIND     = 3'd5;
	localparam logic [2:0] FN_WR_BYTE  = 3'd6;
	localparam logic [2:0] FN_RD_BYTE  = 3'd7;

	// Status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_RANGE = 2'd1;
	localparam logic [1:0] STS_NONE  = 2'd2;

	// Flag entry: bit 0 received, bit 1 deselected
	localparam int FLAG_W = 2;

	typedef struct packed {
		logic [2:0]       func;
		logic [IDX_W-1:0] index;
		logic [CNT_W-1:0] end_index;
		logic [7:0]       byte_in;
	} ppb_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               piece_has;
		logic               piece_selected;
		logic [IDX_W-1:0]   found_index;
		logic [7:0]         byte_out;
		logic [CNT_W-1:0]   received_total;
		logic [CNT_W-1:0]   selected_total;
		logic [CNT_W-1:0]   selected_received_total;
		logic [BYTES_W-1:0] received_bytes;
		logic               all_received;
		logic               selection_complete;
	} ppb_rsp_t;

endpackage

>>> design/ppb_flag_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppb_flag_ram: per-piece flag memory
// Simple dual-port synchronous RAM, one write and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module ppb_flag_ram
	import ppb_pkg::*;
#(
	parameter int DEPTH = PPB_MAX_PIECES,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [FLAG_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [FLAG_W-1:0] rdata
);

	logic [FLAG_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/piece_progress_bitmap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piece_progress_bitmap_unit: per-piece received/deselected store with counts
// Marks pieces received or lost, selects or deselects ranges, queries a
// piece, finds the first unreceived selected piece and moves eight received
// flags as one MSB-first byte. Every response carries the running counts.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+-----------------
//   req     | in  | req_valid / req_stall     | ppb_req_t
//   rsp     | out | rsp_valid / rsp_stall     | ppb_rsp_t
//   apb     | in  | psel / penable / pready   | paddr, pwdata, prdata
//
// One item at a time. A walk reads one flag entry per cycle and writes it back
// the next; point ops walk one entry and byte ops up to 8. Reset and each
// piece_count write start a clear-and-recount sweep over all MAX_PIECES
// entries with req_stall high. A stalled response does not block the next
// transfer on req: the response register sits between the two sides.
// ----------------------------------------------------------------------------
module piece_progress_bitmap_unit
	import ppb_pkg::*;
#(
	parameter int MAX_PIECES = PPB_MAX_PIECES
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	// request channel
	input  logic              req_valid,
	output logic              req_stall,
	input  ppb_req_t          req,
	// response channel
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ppb_rsp_t          rsp
);

	localparam int AW    = $clog2(MAX_PIECES);
	localparam int CUR_W = (AW + 1 > 18) ? AW + 1 : 18;
	localparam logic [CUR_W-1:0] MAX_CUR = CUR_W'(MAX_PIECES);
	localparam logic [31:0]      MAX_32  = 32'(MAX_PIECES);

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_MUL, S_DONE} state_t;

	state_t             state_q;
	logic               sweep_q;
	logic [2:0]         func_q;
	logic [7:0]         byte_q;
	logic [CUR_W-1:0]   cur_q;
	logic [CUR_W-1:0]   end_q;
	logic               vld_s1;
	logic [CUR_W-1:0]   addr_s1;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   zero_lim_q;
	logic [SIZE_W-1:0]  psize_q;
	logic [SIZE_W-1:0]  lsize_q;
	logic [CNT_W-1:0]   rc_q;
	logic [CNT_W-1:0]   dc_q;
	logic [CNT_W-1:0]   src_q;
	logic               last_has_q;
	logic [1:0]         status_q;
	logic               has_q;
	logic               sel_q;
	logic [IDX_W-1:0]   found_q;
	logic [7:0]         bout_q;
	logic [BYTES_W-1:0] prod_q;
	logic               rsp_valid_q;
	ppb_rsp_t           rsp_q;

	// Configuration write decode
	logic             cfg_wr;
	logic             cfg_wr_cnt;
	logic [CNT_W-1:0] cnt_clamped;
	logic [CNT_W-1:0] zero_lim_nxt;

	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite;
	assign cfg_wr_cnt = cfg_wr && (paddr[3:2] == REG_PIECE_COUNT);
	assign cnt_clamped = ({17'd0, pwdata[CNT_W-1:0]} > MAX_32) ? CNT_W'(MAX_PIECES)
	                                                           : pwdata[CNT_W-1:0];
	// An interrupted sweep must still clear everything above its own limit
	assign zero_lim_nxt = (state_q == S_WALK && sweep_q && zero_lim_q < cnt_clamped)
	                      ? zero_lim_q : cnt_clamped;

	// Register readback
	always_comb begin
		case (paddr[3:2])
			REG_PIECE_COUNT: prdata = {{(APB_DW-CNT_W){1'b0}}, n_q};
			REG_PIECE_SIZE:  prdata = {{(APB_DW-SIZE_W){1'b0}}, psize_q};
			REG_LAST_SIZE:   prdata = {{(APB_DW-SIZE_W){1'b0}}, lsize_q};
			default:         prdata = '0;
		endcase
	end

	// Request acceptance and walk bounds
	logic             req_acc;
	logic [CUR_W-1:0] n_w;
	logic [CUR_W-1:0] idx_w;
	logic [CUR_W-1:0] endi_w;
	logic [CUR_W-1:0] base_w;
	logic [CUR_W-1:0] bend_w;
	logic [CUR_W-1:0] acc_cur;
	logic [CUR_W-1:0] acc_end;
	logic [1:0]       acc_status;

	assign req_stall = (state_q != S_IDLE) || cfg_wr_cnt;
	assign req_acc   = req_valid && !req_stall;
	assign n_w       = CUR_W'(n_q);
	assign idx_w     = CUR_W'(req.index);
	assign endi_w    = CUR_W'(req.end_index);
	assign base_w    = CUR_W'({req.index, 3'b000});
	assign bend_w    = base_w + CUR_W'(8);

	always_comb begin
		acc_cur    = '0;
		acc_end    = '0;
		acc_status = STS_OK;
		case (req.func)
			FN_ADD, FN_REMOVE, FN_QUERY: begin
				if (idx_w >= n_w) begin
					acc_status = STS_RANGE;
				end else begin
					acc_cur = idx_w;
					acc_end = idx_w + CUR_W'(1);
				end
			end
			FN_SELECT, FN_DESELECT: begin
				if (idx_w > endi_w || endi_w > n_w) begin
					acc_status = STS_RANGE;
				end else begin
					acc_cur = idx_w;
					acc_end = endi_w;
				end
			end
			FN_FIND: begin
				acc_status = STS_NONE;
				acc_end    = n_w;
			end
			default: begin
				if (base_w >= n_w) begin
					acc_status = STS_RANGE;
				end else begin
					acc_cur = base_w;
					acc_end = (bend_w > n_w) ? n_w : bend_w;
				end
			end
		endcase
	end

	// Flag RAM
	logic              re;
	logic              we;
	logic [FLAG_W-1:0] rd;
	logic [FLAG_W-1:0] nf;

	// the sweep always writes back, so entries that were never written get cleared
	assign re = (state_q == S_WALK) && (cur_q < end_q);
	assign we = vld_s1 && (sweep_q || (nf != rd));

	ppb_flag_ram #(
		.DEPTH (MAX_PIECES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1[AW-1:0]),
		.wdata (nf),
		.re    (re),
		.raddr (cur_q[AW-1:0]),
		.rdata (rd)
	);

	// Entry update for the returning read
	logic       f_has;
	logic       f_unsel;
	logic [2:0] bsel;
	logic       want_set;
	logic       want_clr;
	logic       in_lim;
	logic       is_last;
	logic       find_hit;
	logic       rc_inc, rc_dec, dc_inc, dc_dec, src_inc, src_dec;

	assign f_has   = rd[0];
	assign f_unsel = rd[1];
	assign bsel    = addr_s1[2:0];
	assign in_lim  = addr_s1 < CUR_W'(zero_lim_q);
	assign is_last = (n_q != '0) && (addr_s1 == n_w - CUR_W'(1));
	assign find_hit = vld_s1 && !sweep_q && (func_q == FN_FIND) && (rd == '0);

	always_comb begin
		want_set = 1'b0;
		want_clr = 1'b0;
		case (func_q)
			FN_ADD:     want_set = 1'b1;
			FN_REMOVE:  want_clr = 1'b1;
			FN_WR_BYTE: begin
				want_set = byte_q[3'd7 - bsel];
				want_clr = !byte_q[3'd7 - bsel];
			end
			default: ;
		endcase
	end

	always_comb begin
		nf      = rd;
		rc_inc  = 1'b0;
		rc_dec  = 1'b0;
		dc_inc  = 1'b0;
		dc_dec  = 1'b0;
		src_inc = 1'b0;
		src_dec = 1'b0;
		if (sweep_q) begin
			// recount below the limit, clear above it
			if (in_lim) begin
				rc_inc  = f_has;
				dc_inc  = f_unsel;
				src_inc = f_has && !f_unsel;
			end else begin
				nf = '0;
			end
		end else if (want_set && !f_has) begin
			nf[0]   = 1'b1;
			rc_inc  = 1'b1;
			src_inc = !f_unsel;
		end else if (want_clr && f_has) begin
			nf[0]   = 1'b0;
			rc_dec  = 1'b1;
			src_dec = !f_unsel;
		end else if (func_q == FN_SELECT && f_unsel) begin
			nf[1]   = 1'b0;
			dc_dec  = 1'b1;
			src_inc = f_has;
		end else if (func_q == FN_DESELECT && !f_unsel) begin
			nf[1]   = 1'b1;
			dc_inc  = 1'b1;
			src_dec = f_has;
		end
	end

	// Response assembly
	logic [CNT_W-1:0]   full_cnt;
	logic [CNT_W-1:0]   sel_total;
	logic [BYTES_W-1:0] bytes_sum;
	logic               rsp_load;

	assign full_cnt  = rc_q - CNT_W'(last_has_q);
	assign sel_total = n_q - dc_q;
	assign bytes_sum = prod_q + (last_has_q ? BYTES_W'(lsize_q) : '0);
	assign rsp_load  = (state_q == S_DONE) && !cfg_wr_cnt && (!rsp_valid_q || !rsp_stall);

	// Sequencer, counters and registered response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WALK;
			sweep_q     <= 1'b1;
			func_q      <= FN_ADD;
			byte_q      <= '0;
			cur_q       <= '0;
			end_q       <= MAX_CUR;
			vld_s1      <= 1'b0;
			addr_s1     <= '0;
			n_q         <= '0;
			zero_lim_q  <= '0;
			psize_q     <= SIZE_W'(16384);
			lsize_q     <= SIZE_W'(16384);
			rc_q        <= '0;
			dc_q        <= '0;
			src_q       <= '0;
			last_has_q  <= 1'b0;
			status_q    <= STS_OK;
			has_q       <= 1'b0;
			sel_q       <= 1'b0;
			found_q     <= '0;
			bout_q      <= '0;
			prod_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// response register loads a new item or drains on transfer
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			// size registers
			if (cfg_wr && paddr[3:2] == REG_PIECE_SIZE) begin
				psize_q <= pwdata[SIZE_W-1:0];
			end
			if (cfg_wr && paddr[3:2] == REG_LAST_SIZE) begin
				lsize_q <= pwdata[SIZE_W-1:0];
			end

			if (cfg_wr_cnt) begin
				// new piece count: restart the clear-and-recount sweep
				n_q        <= cnt_clamped;
				zero_lim_q <= zero_lim_nxt;
				state_q    <= S_WALK;
				sweep_q    <= 1'b1;
				cur_q      <= '0;
				end_q      <= MAX_CUR;
				vld_s1     <= 1'b0;
				rc_q       <= '0;
				dc_q       <= '0;
				src_q      <= '0;
				last_has_q <= 1'b0;
			end else begin
				// counter and capture updates for the returning entry
				if (vld_s1) begin
					rc_q  <= rc_q + CNT_W'(rc_inc) - CNT_W'(rc_dec);
					dc_q  <= dc_q + CNT_W'(dc_inc) - CNT_W'(dc_dec);
					src_q <= src_q + CNT_W'(src_inc) - CNT_W'(src_dec);
					if (is_last && (sweep_q ? in_lim : 1'b1)) begin
						last_has_q <= nf[0];
					end
					if (!sweep_q && func_q == FN_QUERY) begin
						has_q <= f_has;
						sel_q <= !f_unsel;
					end
					if (!sweep_q && func_q == FN_RD_BYTE) begin
						bout_q[3'd7 - bsel] <= f_has;
					end
				end

				case (state_q)
					S_IDLE: begin
						if (req_acc) begin
							func_q   <= req.func;
							byte_q   <= req.byte_in;
							status_q <= acc_status;
							cur_q    <= acc_cur;
							end_q    <= acc_end;
							has_q    <= 1'b0;
							sel_q    <= 1'b0;
							found_q  <= '0;
							bout_q   <= '0;
							state_q  <= S_WALK;
						end
					end
					S_WALK: begin
						if (re) begin
							cur_q <= cur_q + CUR_W'(1);
						end
						// a find hit drops the read still in flight
						vld_s1  <= re && !find_hit;
						addr_s1 <= cur_q;
						if (find_hit) begin
							status_q <= STS_OK;
							found_q  <= addr_s1[IDX_W-1:0];
							state_q  <= S_MUL;
						end else if (!re && !vld_s1) begin
							if (sweep_q) begin
								sweep_q <= 1'b0;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_MUL;
							end
						end
					end
					S_MUL: begin
						prod_q  <= full_cnt * psize_q;
						state_q <= S_DONE;
					end
					S_DONE: begin
						if (rsp_load) begin
							rsp_q.status                  <= status_q;
							rsp_q.piece_has               <= has_q;
							rsp_q.piece_selected          <= sel_q;
							rsp_q.found_index             <= found_q;
							rsp_q.byte_out                <= bout_q;
							rsp_q.received_total          <= rc_q;
							rsp_q.selected_total          <= sel_total;
							rsp_q.selected_received_total <= src_q;
							rsp_q.received_bytes          <= bytes_sum;
							rsp_q.all_received            <= (rc_q == n_q);
							rsp_q.selection_complete      <= (src_q == sel_total);
							state_q                       <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	// Write-back never collides with the read issued in the same cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re && addr_s1[AW-1:0] == cur_q[AW-1:0]))
		else $error("flag RAM read and write hit the same entry");

	// Selected-received count never exceeds the received count
	a_src_le_rc: assert property (@(posedge clk) disable iff (!arst_n)
		src_q <= rc_q)
		else $error("selected received count above received count");

	// Between items the counts stay within the piece count
	a_idle_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (rc_q <= n_q && dc_q <= n_q))
		else $error("counts exceed piece count while idle");
`endif

endmodule
